@@ hdl/grid_cell_locate_and_fetch_top_macros.svh @@
// Assertion macros for the grid cell locator RTL.
`ifndef GRID_CELL_LOCATE_AND_FETCH_TOP_MACROS_SVH
`define GRID_CELL_LOCATE_AND_FETCH_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define GCLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gclf_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
`default_nettype none
package gclf_pkg;

    // table sizes
    localparam int unsigned MAX_RADIAL     = 64;
    localparam int unsigned MAX_AXIAL      = 64;
    localparam int unsigned PRESSURE_DEPTH = 8192;

    localparam int unsigned RADIAL_AW = $clog2(MAX_RADIAL);
    localparam int unsigned AXIAL_AW  = $clog2(MAX_AXIAL);
    localparam int unsigned PRESS_AW  = $clog2(PRESSURE_DEPTH);

    localparam int unsigned WALK_N  = (MAX_RADIAL > MAX_AXIAL) ? MAX_RADIAL : MAX_AXIAL;
    localparam int unsigned WALK_AW = $clog2(WALK_N);
    localparam int unsigned WALK_CW = WALK_AW + 1;

    // field widths
    localparam int unsigned ACTION_W    = 2;
    localparam int unsigned IDX_W       = 13;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned RIDX_W      = 6;
    localparam int unsigned AIDX_W      = 6;
    localparam int unsigned CELL_IDX_W  = 13;
    localparam int unsigned CFG_W       = 7;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned IN_TDATA_W  = 144;
    localparam int unsigned OUT_TDATA_W = 64;

    // running width sum never overflows over the whole walk
    localparam int unsigned SUM_W  = DATA_W + WALK_AW + 1;
    localparam int unsigned CELL_W = CFG_W + AXIAL_AW + 2;

    localparam logic [CFG_W-1:0] RADIAL_COUNT_RST = 7'd64;
    localparam logic [CFG_W-1:0] AXIAL_COUNT_RST  = 7'd64;
    localparam logic [CFG_W-1:0] ROW_STRIDE_RST   = 7'd66;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_RADIAL   = 2'd0,
        ACT_WR_AXIAL    = 2'd1,
        ACT_WR_PRESSURE = 2'd2,
        ACT_QUERY       = 2'd3
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RADIAL_COUNT = 2'd0,
        CFG_AXIAL_COUNT  = 2'd1,
        CFG_ROW_STRIDE   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               accept;     // input word taken this cycle
        logic               flush;      // clear walk pipeline and running sum
        logic               issue;      // read one width entry
        logic [WALK_AW-1:0] rd_addr;
        logic               rd_last;    // entry being read is the last one in use
        logic               axial;      // walk runs over axial table
        logic               cap;        // capture walk result
        logic               cap_empty;  // nothing walked: index 0, outside
        logic               calc_cell;
        logic               fetch;
        logic               load_out;
    } gclf_cmd_t;

    typedef struct packed {
        logic p3_vld;
        logic p3_last;
        logic hit;
        logic z_neg;
    } gclf_status_t;

    function automatic logic [WALK_CW-1:0] clamp_count(input logic [CFG_W-1:0] count,
                                                       input int unsigned limit);
        logic [WALK_CW-1:0] result;
        if (32'(count) > limit)
            result = WALK_CW'(limit);
        else
            result = WALK_CW'(count);
        return result;
    endfunction

endpackage
`default_nettype wire

@@ hdl/grid_cell_locate_and_fetch_top.sv @@
// Cylindrical grid cell locator: top level with ports and configuration registers.
//
// One word in, one word out. Write words (radial width, axial width,
// pressure) are stored at the accepting edge; their acknowledge word is
// loaded into the output register in the done state, and the next word can
// be taken in the same cycle that the acknowledge becomes valid. A query
// walks the radial width table one entry per cycle, then the axial table,
// then reads the pressure word; the next word can be taken in the same cycle
// that the result becomes valid. A walk with nothing to do (zero cell count,
// or negative z for the axial walk) reads no table entry and captures index
// 0 as outside. The walk timing is set by the single read port of each width
// RAM and the read/accumulate/square-compare pipeline that each walk has to
// drain. One query is worked on at a time; a finished result waits in the
// output register. Width and pressure tables have no reset state and must be
// written before a query reads them.
`default_nettype none
module grid_cell_locate_and_fetch_top import gclf_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // entry_index, entry_value, coord_x, coord_y, coord_z, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // action
    input  wire logic [ACTION_W-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // radial_index, axial_index, cell_index, outside, pressure, zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // is_query
    output logic                        m_tuser,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    logic [CFG_W-1:0]          radial_count_reg, axial_count_reg, row_stride_reg;
    gclf_cmd_t                 cmd;
    gclf_status_t              st;
    action_t                   in_action;

    logic                      out_is_query;
    logic [RIDX_W-1:0]         out_radial_index;
    logic [AIDX_W-1:0]         out_axial_index;
    logic [CELL_IDX_W-1:0]     out_cell_index;
    logic                      out_outside;
    logic signed [DATA_W-1:0]  out_pressure;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radial_count_reg <= RADIAL_COUNT_RST;
            axial_count_reg  <= AXIAL_COUNT_RST;
            row_stride_reg   <= ROW_STRIDE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_RADIAL_COUNT: radial_count_reg <= cfg_wdata;
                CFG_AXIAL_COUNT:  axial_count_reg  <= cfg_wdata;
                CFG_ROW_STRIDE:   row_stride_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign in_action = action_t'(s_tuser);

    gclf_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_action         (in_action),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .cfg_radial_count (radial_count_reg),
        .cfg_axial_count  (axial_count_reg),
        .st               (st),
        .cmd              (cmd)
    );

    gclf_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .in_action        (in_action),
        .in_entry_index   (s_tdata[12:0]),
        .in_entry_value   (s_tdata[44:13]),
        .in_coord_x       (s_tdata[76:45]),
        .in_coord_y       (s_tdata[108:77]),
        .in_coord_z       (s_tdata[140:109]),
        .cfg_row_stride   (row_stride_reg),
        .out_is_query     (out_is_query),
        .out_radial_index (out_radial_index),
        .out_axial_index  (out_axial_index),
        .out_cell_index   (out_cell_index),
        .out_outside      (out_outside),
        .out_pressure     (out_pressure)
    );

    assign m_tdata = {6'd0, out_pressure, out_outside, out_cell_index,
                      out_axial_index, out_radial_index};
    assign m_tuser = out_is_query;

endmodule
`default_nettype wire

@@ hdl/gclf_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module gclf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we)
                mem[addr] <= wdata;
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/gclf_dp.sv @@
// Datapath: width tables, walk pipeline, cell number and pressure fetch.
`default_nettype none
module gclf_dp import gclf_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire gclf_cmd_t                 cmd,
    output gclf_status_t                   st,
    input  wire action_t                   in_action,
    input  wire logic [IDX_W-1:0]          in_entry_index,
    input  wire logic signed [DATA_W-1:0]  in_entry_value,
    input  wire logic signed [DATA_W-1:0]  in_coord_x,
    input  wire logic signed [DATA_W-1:0]  in_coord_y,
    input  wire logic signed [DATA_W-1:0]  in_coord_z,
    input  wire logic [CFG_W-1:0]          cfg_row_stride,
    output logic                           out_is_query,
    output logic [RIDX_W-1:0]              out_radial_index,
    output logic [AIDX_W-1:0]              out_axial_index,
    output logic [CELL_IDX_W-1:0]          out_cell_index,
    output logic                           out_outside,
    output logic signed [DATA_W-1:0]       out_pressure
);

    logic                      is_query_reg;
    logic signed [DATA_W-1:0]  x_reg, y_reg, z_reg;
    logic signed [2*DATA_W-1:0] xx_reg, yy_reg;
    logic [2*DATA_W-1:0]       r2_reg;

    logic                      wr_rad, wr_ax, wr_press;
    logic [DATA_W-1:0]         rad_rdata, ax_rdata, press_rdata;
    logic [DATA_W-1:0]         walk_data;

    logic                      p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [WALK_AW-1:0]        p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic                      p1_last_reg, p2_last_reg, p3_last_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [2*DATA_W-1:0]       sq_reg;
    logic                      pos_reg, big_reg, gtz_reg;
    logic                      hit;

    logic [RADIAL_AW-1:0]      rad_idx_reg;
    logic [AXIAL_AW-1:0]       ax_idx_reg;
    logic                      outside_reg;
    logic [WALK_AW-1:0]        cap_idx;
    logic [CELL_W-1:0]         cell_reg;

    // table writes happen in the cycle the word is accepted
    assign wr_rad   = cmd.accept && (in_action == ACT_WR_RADIAL)
                      && (32'(in_entry_index) < MAX_RADIAL);
    assign wr_ax    = cmd.accept && (in_action == ACT_WR_AXIAL)
                      && (32'(in_entry_index) < MAX_AXIAL);
    assign wr_press = cmd.accept && (in_action == ACT_WR_PRESSURE)
                      && (32'(in_entry_index) < PRESSURE_DEPTH);

    gclf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_RADIAL)) u_radial_ram (
        .aclk  (aclk),
        .en    (wr_rad || cmd.issue),
        .we    (wr_rad),
        .addr  (cmd.accept ? RADIAL_AW'(in_entry_index) : RADIAL_AW'(cmd.rd_addr)),
        .wdata (in_entry_value),
        .rdata (rad_rdata)
    );

    gclf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_AXIAL)) u_axial_ram (
        .aclk  (aclk),
        .en    (wr_ax || cmd.issue),
        .we    (wr_ax),
        .addr  (cmd.accept ? AXIAL_AW'(in_entry_index) : AXIAL_AW'(cmd.rd_addr)),
        .wdata (in_entry_value),
        .rdata (ax_rdata)
    );

    gclf_ram #(.WIDTH(DATA_W), .DEPTH(PRESSURE_DEPTH)) u_pressure_ram (
        .aclk  (aclk),
        .en    (wr_press || cmd.fetch),
        .we    (wr_press),
        .addr  (cmd.accept ? PRESS_AW'(in_entry_index) : PRESS_AW'(cell_reg)),
        .wdata (in_entry_value),
        .rdata (press_rdata)
    );

    // query capture and r^2 = x*x + y*y, registered in x/y, then xx/yy, then r2
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            is_query_reg <= (in_action == ACT_QUERY);
            x_reg        <= in_coord_x;
            y_reg        <= in_coord_y;
            z_reg        <= in_coord_z;
        end
        xx_reg <= x_reg * x_reg;
        yy_reg <= y_reg * y_reg;
        r2_reg <= $unsigned(xx_reg) + $unsigned(yy_reg);
    end

    assign walk_data = cmd.axial ? ax_rdata : rad_rdata;

    // walk pipeline: RAM read, accumulate, square/compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else if (cmd.flush) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= cmd.issue;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg  <= cmd.rd_addr;
        p1_last_reg <= cmd.rd_last;
        p2_idx_reg  <= p1_idx_reg;
        p2_last_reg <= p1_last_reg;
        p3_idx_reg  <= p2_idx_reg;
        p3_last_reg <= p2_last_reg;

        if (cmd.flush)
            sum_reg <= '0;
        else if (p1_vld_reg)
            sum_reg <= sum_reg + $signed({{(SUM_W-DATA_W){walk_data[DATA_W-1]}}, walk_data});

        sq_reg  <= sum_reg[DATA_W-1:0] * sum_reg[DATA_W-1:0];
        pos_reg <= (sum_reg > 0);
        // sum at or above 2^32 is beyond any radius
        big_reg <= !sum_reg[SUM_W-1] && (|sum_reg[SUM_W-2:DATA_W]);
        gtz_reg <= (sum_reg > $signed({{(SUM_W-DATA_W){z_reg[DATA_W-1]}}, z_reg}));
    end

    assign hit = cmd.axial ? gtz_reg : (pos_reg && (big_reg || (sq_reg > r2_reg)));

    always_comb begin
        st.p3_vld  = p3_vld_reg;
        st.p3_last = p3_last_reg;
        st.hit     = hit;
        st.z_neg   = z_reg[DATA_W-1];
    end

    // walk result; the last entry's index is also the clamp value
    assign cap_idx = cmd.cap_empty ? '0 : p3_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept)
            outside_reg <= 1'b0;
        else if (cmd.cap)
            outside_reg <= outside_reg || cmd.cap_empty || !hit;

        if (cmd.cap && !cmd.axial)
            rad_idx_reg <= RADIAL_AW'(cap_idx);
        if (cmd.cap && cmd.axial)
            ax_idx_reg <= AXIAL_AW'(cap_idx);

        if (cmd.calc_cell)
            cell_reg <= CELL_W'(cfg_row_stride) * (CELL_W'(ax_idx_reg) + CELL_W'(1))
                        + CELL_W'(rad_idx_reg) + CELL_W'(1);
    end

    // result word; write acks carry zeros
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_is_query <= is_query_reg;
            if (is_query_reg) begin
                out_radial_index <= RIDX_W'(rad_idx_reg);
                out_axial_index  <= AIDX_W'(ax_idx_reg);
                out_cell_index   <= CELL_IDX_W'(cell_reg);
                out_outside      <= outside_reg;
                out_pressure     <= press_rdata;
            end else begin
                out_radial_index <= '0;
                out_axial_index  <= '0;
                out_cell_index   <= '0;
                out_outside      <= 1'b0;
                out_pressure     <= '0;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/gclf_ctrl.sv @@
// Controller: sequences table writes, the two walks, cell fetch and result.
`default_nettype none
`include "grid_cell_locate_and_fetch_top_macros.svh"
module gclf_ctrl import gclf_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire action_t          s_action,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [CFG_W-1:0] cfg_radial_count,
    input  wire logic [CFG_W-1:0] cfg_axial_count,
    input  wire gclf_status_t     st,
    output gclf_cmd_t             cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RWALK = 6'b000010,
        ST_ZWALK = 6'b000100,
        ST_CELL  = 6'b001000,
        ST_FETCH = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [WALK_CW-1:0] cnt_reg, cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [WALK_CW-1:0] n_rad, n_ax, walk_n;
    logic               accept;
    state_t             walk_exit;

    assign n_rad  = clamp_count(cfg_radial_count, MAX_RADIAL);
    assign n_ax   = clamp_count(cfg_axial_count, MAX_AXIAL);
    assign walk_n = (state_reg == ST_ZWALK) ? n_ax : n_rad;
    assign walk_exit = (state_reg == ST_ZWALK) ? ST_CELL : ST_ZWALK;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.axial     = (state_reg == ST_ZWALK);
        cmd.rd_addr   = cnt_reg[WALK_AW-1:0];
        cmd.rd_last   = (cnt_reg == walk_n - WALK_CW'(1));
        state_next    = state_reg;
        cnt_next      = cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_QUERY) begin
                        cmd.flush  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_RWALK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RWALK, ST_ZWALK: begin
                if ((walk_n == '0) || (cmd.axial && st.z_neg)) begin
                    cmd.cap       = 1'b1;
                    cmd.cap_empty = 1'b1;
                    cmd.flush     = 1'b1;
                    cnt_next      = '0;
                    state_next    = walk_exit;
                end else if (st.p3_vld && (st.hit || st.p3_last)) begin
                    // first hit wins; entries still in flight are dropped
                    cmd.cap    = 1'b1;
                    cmd.flush  = 1'b1;
                    cnt_next   = '0;
                    state_next = walk_exit;
                end else if (cnt_reg < walk_n) begin
                    cmd.issue = 1'b1;
                    cnt_next  = cnt_reg + WALK_CW'(1);
                end
            end
            ST_CELL: begin
                cmd.calc_cell = 1'b1;
                state_next    = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `GCLF_ASSERT_NOW(a_load_when_free, cmd.load_out, !m_tvalid_reg || m_tready, "result overwritten before taken")
    `GCLF_ASSERT_NOW(a_no_issue_on_flush, cmd.issue, !cmd.flush, "read issued during flush")
    `GCLF_ASSERT_NOW(a_issue_in_range, cmd.issue, cnt_reg < walk_n, "read beyond cells in use")
    `GCLF_ASSERT_NOW(a_p3_only_walking, st.p3_vld, (state_reg == ST_RWALK) || (state_reg == ST_ZWALK), "walk stage valid outside a walk")
    `GCLF_ASSERT_NEXT(a_query_starts_walk, accept && (s_action == ACT_QUERY), state_reg == ST_RWALK, "query did not start radial walk")

endmodule
`default_nettype wire

@@ bench/grid_cell_locate_and_fetch_top_test.sv @@
// Self-checking bench for the grid cell locator: table loads, queries, result checks.
`timescale 1ns / 1ps
module grid_cell_locate_and_fetch_top_test;
    import gclf_pkg::*;

    typedef struct packed {
        action_t     action;
        logic [12:0] entry_index;
        logic [31:0] entry_value;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
    } grid_word_t;

    typedef struct packed {
        logic        is_query;
        logic [5:0]  radial_index;
        logic [5:0]  axial_index;
        logic [12:0] cell_index;
        logic        outside;
        logic [31:0] pressure;
    } cell_result_t;

    localparam longint RADIUS_CAP = 64'sh1_0000_0000;
    localparam longint UNIT       = 65536;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [ACTION_W-1:0]    s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    // shadow copy of the tables and registers
    bit [31:0]  radial_w [MAX_RADIAL];
    bit [31:0]  axial_w [MAX_AXIAL];
    bit [31:0]  press_w [PRESSURE_DEPTH];
    bit         press_loaded [PRESSURE_DEPTH];
    logic [6:0] radial_count = RADIAL_COUNT_RST;
    logic [6:0] axial_count  = AXIAL_COUNT_RST;
    logic [6:0] row_stride   = ROW_STRIDE_RST;

    grid_word_t   words_to_send[$];
    cell_result_t expected_results[$];

    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_len       = 0;
    int hold_left      = 0;

    int         idle_plan   [8] = '{0, 80, 0, 33, 0, 80, 0, 33};
    int         stall_plan  [8] = '{0, 0, 80, 33, 0, 0, 80, 33};
    logic [6:0] radial_plan [8] = '{64, 12, 30, 0, 127, 1, 64, 64};
    logic [6:0] axial_plan  [8] = '{64, 20, 30, 0, 127, 1, 5, 64};
    logic [6:0] stride_plan [8] = '{66, 14, 33, 0, 127, 1, 127, 66};
    bit         mixed_plan  [8] = '{0, 0, 1, 0, 1, 0, 0, 0};

    grid_cell_locate_and_fetch_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic bit beyond_radius(input longint run, input bit [63:0] r2);
        bit [63:0] s;
        if (run <= 0)
            return 1'b0;
        if (run >= RADIUS_CAP)
            return 1'b1;
        s = run;
        return (s * s) > r2;
    endfunction

    // updates the shadow tables for writes, returns the result word the block owes
    function automatic cell_result_t locate_and_fetch(input grid_word_t w);
        cell_result_t res;
        longint       x, y, z, run;
        bit [63:0]    r2, sq;
        int           nr, nz, i, j;
        bit           hit, outside;
        int unsigned  cellnum;
        res = '0;
        case (w.action)
            ACT_WR_RADIAL: begin
                if (w.entry_index < MAX_RADIAL)
                    radial_w[w.entry_index] = w.entry_value;
            end
            ACT_WR_AXIAL: begin
                if (w.entry_index < MAX_AXIAL)
                    axial_w[w.entry_index] = w.entry_value;
            end
            ACT_WR_PRESSURE: begin
                if (w.entry_index < PRESSURE_DEPTH)
                    press_w[w.entry_index] = w.entry_value;
            end
            default: begin
                x = $signed(w.coord_x);
                y = $signed(w.coord_y);
                z = $signed(w.coord_z);
                sq = x * x;
                r2 = sq;
                sq = y * y;
                r2 = r2 + sq;
                nr = (radial_count > MAX_RADIAL) ? MAX_RADIAL : radial_count;
                nz = (axial_count > MAX_AXIAL) ? MAX_AXIAL : axial_count;
                outside = 1'b0;

                run = 0;
                hit = 1'b0;
                i = 0;
                while (!hit && i < nr) begin
                    run += $signed(radial_w[i]);
                    if (beyond_radius(run, r2))
                        hit = 1'b1;
                    else
                        i++;
                end
                if (!hit) begin
                    outside = 1'b1;
                    i = (nr > 0) ? nr - 1 : 0;
                end

                j = 0;
                if (z < 0) begin
                    outside = 1'b1;
                end else begin
                    run = 0;
                    hit = 1'b0;
                    while (!hit && j < nz) begin
                        run += $signed(axial_w[j]);
                        if (run > z)
                            hit = 1'b1;
                        else
                            j++;
                    end
                    if (!hit) begin
                        outside = 1'b1;
                        j = (nz > 0) ? nz - 1 : 0;
                    end
                end

                cellnum = row_stride * (j + 1) + i + 1;
                res.is_query     = 1'b1;
                res.radial_index = 6'(i);
                res.axial_index  = 6'(j);
                res.cell_index   = 13'(cellnum);
                res.outside      = outside;
                res.pressure     = press_w[13'(cellnum)];
            end
        endcase
        return res;
    endfunction

    function automatic grid_word_t random_word();
        grid_word_t w;
        w.action      = action_t'($urandom_range(0, 3));
        w.entry_index = 13'($urandom);
        w.entry_value = $urandom;
        w.coord_x     = $urandom;
        w.coord_y     = $urandom;
        w.coord_z     = $urandom;
        return w;
    endfunction

    function automatic logic [31:0] width_value(input bit mixed);
        int pick;
        pick = mixed ? $urandom_range(0, 99) : 0;
        if (pick < 60)
            return $urandom_range(32'(4 * UNIT), 32'(UNIT));
        if (pick < 75)
            return 32'd0;
        if (pick < 90)
            return -$urandom_range(32'(4 * UNIT), 1);
        return $urandom;
    endfunction

    // sum of the positive widths in use, kept to a span that random coordinates can reach
    function automatic longint grid_reach(input bit axial);
        longint run, wv;
        int     n, k;
        run = 0;
        if (axial)
            n = (axial_count > MAX_AXIAL) ? MAX_AXIAL : axial_count;
        else
            n = (radial_count > MAX_RADIAL) ? MAX_RADIAL : radial_count;
        for (k = 0; k < n; k++) begin
            wv = axial ? $signed(axial_w[k]) : $signed(radial_w[k]);
            if (wv > 0)
                run += wv;
        end
        if (run < UNIT)
            run = UNIT;
        if (run > 64'sd1073741824)
            run = 64'sd1073741824;
        return run;
    endfunction

    function automatic logic [31:0] rand_between(input longint lo, input longint hi);
        return 32'(lo + longint'($urandom_range(32'(hi - lo), 0)));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic push_word(input grid_word_t w);
        if (w.action == ACT_WR_PRESSURE)
            press_loaded[w.entry_index] = 1'b1;
        words_to_send.push_back(w);
        expected_results.push_back(locate_and_fetch(w));
    endtask

    // a query never reads a pressure word that was not written: load it first
    task automatic queue_word(input grid_word_t w);
        cell_result_t res;
        grid_word_t   fill;
        if (w.action == ACT_QUERY) begin
            res = locate_and_fetch(w);
            if (!press_loaded[res.cell_index]) begin
                fill = random_word();
                fill.action = ACT_WR_PRESSURE;
                fill.entry_index = res.cell_index;
                push_word(fill);
            end
        end
        push_word(w);
    endtask

    task automatic queue_directed(input action_t act, input logic [12:0] idx,
                                  input logic [31:0] val, input logic [31:0] x,
                                  input logic [31:0] y, input logic [31:0] z);
        grid_word_t w;
        w = '{act, idx, val, x, y, z};
        queue_word(w);
    endtask

    task automatic load_widths(input bit mixed);
        grid_word_t w;
        int         k;
        for (k = 0; k < MAX_RADIAL; k++) begin
            w = random_word();
            w.action = ACT_WR_RADIAL;
            w.entry_index = 13'(k);
            w.entry_value = width_value(mixed);
            queue_word(w);
            w.action = ACT_WR_AXIAL;
            w.entry_value = width_value(mixed);
            queue_word(w);
        end
    endtask

    task automatic queue_random(input bit mixed);
        grid_word_t w;
        int         pick;
        longint     rr, zr;
        w = random_word();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            w.action = ACT_QUERY;
            // most queries land near the grid, the rest keep fully random coordinates
            if (pick < 36) begin
                rr = grid_reach(1'b0) * 3 / 4;
                zr = grid_reach(1'b1);
                w.coord_x = rand_between(-rr, rr);
                w.coord_y = rand_between(-rr, rr);
                w.coord_z = rand_between(-zr / 16, zr + zr / 16);
            end
        end else if (pick < 60) begin
            w.action = ACT_WR_RADIAL;
            w.entry_index = 13'($urandom_range(MAX_RADIAL - 1, 0));
            w.entry_value = width_value(mixed);
        end else if (pick < 75) begin
            w.action = ACT_WR_AXIAL;
            w.entry_index = 13'($urandom_range(MAX_AXIAL - 1, 0));
            w.entry_value = width_value(mixed);
        end else if (pick < 95) begin
            w.action = ACT_WR_PRESSURE;
        end
        queue_word(w);
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic program_grid(input logic [6:0] nr, input logic [6:0] nz,
                                input logic [6:0] st);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_RADIAL_COUNT;
        cfg_wdata <= nr;
        @(posedge aclk);
        cfg_addr  <= CFG_AXIAL_COUNT;
        cfg_wdata <= nz;
        @(posedge aclk);
        cfg_addr  <= CFG_ROW_STRIDE;
        cfg_wdata <= st;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        radial_count = nr;
        axial_count  = nz;
        row_stride   = st;
    endtask

    always @(posedge aclk) begin : word_driver
        grid_word_t next_word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (words_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                next_word = words_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, next_word.coord_z, next_word.coord_y, next_word.coord_x,
                             next_word.entry_value, next_word.entry_index};
                s_tuser  <= next_word.action;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_left <= hold_len;
            hold_seen <= hold_seq;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_results.pop_front();
                check_field("is_query", m_tuser, want.is_query);
                check_field("radial_index", m_tdata[5:0], want.radial_index);
                check_field("axial_index", m_tdata[11:6], want.axial_index);
                check_field("cell_index", m_tdata[24:12], want.cell_index);
                check_field("outside", m_tdata[25], want.outside);
                check_field("pressure", m_tdata[57:26], want.pressure);
            end
        end
    end

    initial begin : stimulus
        int p, k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        program_grid(RADIAL_COUNT_RST, AXIAL_COUNT_RST, ROW_STRIDE_RST);
        load_widths(1'b0);

        // origin, extreme coordinates, negative z
        queue_directed(ACT_QUERY, 13'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_QUERY, 13'd5, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        queue_directed(ACT_QUERY, 13'd0, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        queue_directed(ACT_QUERY, 13'd0, 32'd0, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
        // exactly on the first cell boundary, then just inside
        queue_directed(ACT_QUERY, 13'd0, 32'd0, radial_w[0], 32'd0, axial_w[0]);
        queue_directed(ACT_QUERY, 13'd0, 32'd0, radial_w[0] - 1, 32'd0, axial_w[0] - 1);
        // width writes beyond the tables are acknowledged and dropped
        queue_directed(ACT_WR_RADIAL, 13'd8191, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_WR_RADIAL, 13'd64, 32'h7fff_ffff, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_WR_AXIAL, 13'd64, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_WR_AXIAL, 13'd8191, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_WR_PRESSURE, 13'd8191, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_WR_PRESSURE, 13'd0, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
        // largest widths at both ends of the radial table
        queue_directed(ACT_WR_RADIAL, 13'd63, 32'h7fff_ffff, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_QUERY, 13'd0, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
        queue_directed(ACT_WR_RADIAL, 13'd0, 32'h7fff_ffff, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_QUERY, 13'd0, 32'd0, 32'h4000_0000, 32'd0, 32'h0001_0000);
        queue_directed(ACT_WR_RADIAL, 13'd0, 32'h0002_0000, 32'd0, 32'd0, 32'd0);
        queue_directed(ACT_WR_RADIAL, 13'd63, 32'h0003_0000, 32'd0, 32'd0, 32'd0);
        wait_drained();

        for (p = 0; p < 8; p++) begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            program_grid(radial_plan[p], axial_plan[p], stride_plan[p]);
            if (p > 0 && mixed_plan[p] != mixed_plan[p - 1])
                load_widths(mixed_plan[p]);
            if (p == 0) begin
                // result side blocked while words keep coming
                hold_len = 600;
                hold_seq++;
            end
            for (k = 0; k < 65; k++)
                queue_random(mixed_plan[p]);
            wait_drained();
            for (k = 0; k < 65; k++)
                queue_random(mixed_plan[p]);
            wait_drained();
        end

        repeat (150) @(posedge aclk);
        if (mismatches == 0)
            $display("grid_cell_locate_and_fetch_top regression: pass");
        else
            $display("grid_cell_locate_and_fetch_top regression: fail");
        $finish;
    end

    initial begin : watchdog
        #30ms;
        $display("grid_cell_locate_and_fetch_top regression: fail");
        $finish;
    end

endmodule
